[rtl/core/assert_macros.svh]
// assertion helpers used by the rtl controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// condition must hold in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/rlss_pkg.sv]
package rlss_pkg;

    // default strip capacity
    localparam int MAX_LEDS_DEF = 64;

    // operation codes
    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_SHOW  = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_LED_COUNT  = 3'd0;
    localparam logic [2:0] CFG_ONE_HIGH   = 3'd1;
    localparam logic [2:0] CFG_ONE_LOW    = 3'd2;
    localparam logic [2:0] CFG_ZERO_HIGH  = 3'd3;
    localparam logic [2:0] CFG_ZERO_LOW   = 3'd4;
    localparam logic [2:0] CFG_LATCH      = 3'd5;

    // configuration reset values
    localparam logic [6:0]  RST_LED_COUNT = 7'd8;
    localparam logic [15:0] RST_ONE_HIGH  = 16'd40;
    localparam logic [15:0] RST_ONE_LOW   = 16'd22;
    localparam logic [15:0] RST_ZERO_HIGH = 16'd20;
    localparam logic [15:0] RST_ZERO_LOW  = 16'd42;
    localparam logic [15:0] RST_LATCH     = 16'd2500;

    // brightness clamp and divide-by-100 reciprocal (exact for products below 25600)
    localparam logic [7:0]  BRIGHT_MAX   = 8'd100;
    localparam logic [12:0] DIV100_MULT  = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    // last bit position of a 24-bit pixel
    localparam logic [4:0] LAST_BIT = 5'd23;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_LATCH
    } line_phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_DIV
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic fetch;
        logic mul;
        logic div;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_fetch;
        logic is_set;
    } stat_t;

endpackage

[rtl/core/rgb_led_strip_serializer_top.sv]
// rgb led strip serializer: pixel store plus one-wire led line driver
// input channel (s_valid/s_ready) takes one operation per transaction:
//   set pixel, clear all, start show, or tick (one clock of the line waveform)
// result channel (m_valid/m_ready) returns one transaction per input:
//   line level during that item, busy flag after it, and whether it took effect
// config port: cfg_we with cfg_index and cfg_wdata
// the result is registered and presented in the cycle after the input is accepted
// a tick, a clear or a refused operation leaves the controller idle for the next input;
//   a tick that moves to the next pixel and a start show with pixels to send first pass
//   a fetch state reading the pixel store port; a set pixel on an idle line passes a
//   state registering the brightness products and one writing the divided word
// a result waiting on a stalled receiver sits in the output register; the next
//   input is taken in the same cycle the receiver takes that result
// reset (aresetn low, synchronous): registers return to defaults, all pixels
//   read as zero, the line goes idle; no clearing pass is needed
// operations other than tick are refused while a frame or latch period runs
module rgb_led_strip_serializer_top
    import rlss_pkg::*;
#(
    parameter int MAX_LEDS = MAX_LEDS_DEF
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_pixel_index,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic [7:0]  s_brightness,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_line_level,
    output logic        m_busy_res,
    output logic        m_accepted
);

    cmd_t  cmd;
    stat_t stat;

    // sequencing and handshakes
    rlss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // pixel store, dimmer and line timing
    rlss_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_operation   (s_operation),
        .s_pixel_index (s_pixel_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_brightness  (s_brightness),
        .cmd           (cmd),
        .stat          (stat),
        .m_line_level  (m_line_level),
        .m_busy_res    (m_busy_res),
        .m_accepted    (m_accepted)
    );

endmodule

[rtl/core/rlss_ctrl.sv]
`include "assert_macros.svh"

module rlss_ctrl
    import rlss_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    // state and result slot registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        s_ready    = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
        cmd.exec   = s_valid && s_ready;
        cmd.fetch  = (state_reg == ST_FETCH);
        cmd.mul    = (state_reg == ST_MUL);
        cmd.div    = (state_reg == ST_DIV);
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.exec) begin
                    if (stat.is_set) begin
                        state_next = ST_MUL;
                    end else if (stat.need_fetch) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: state_next = ST_IDLE;
            ST_MUL:   state_next = ST_DIV;
            ST_DIV:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
        // result slot: filled on accept, emptied when taken
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    `ASSERT_NEXT(a_exec_fills_slot, aclk, aresetn, cmd.exec, m_valid_reg)
    `ASSERT_NEXT(a_set_enters_mul, aclk, aresetn, cmd.exec && stat.is_set, state_reg == ST_MUL)
    `ASSERT_NEXT(a_mul_then_div, aclk, aresetn, state_reg == ST_MUL, state_reg == ST_DIV)

endmodule

[rtl/core/rlss_datapath.sv]
module rlss_datapath
    import rlss_pkg::*;
#(
    parameter int MAX_LEDS = MAX_LEDS_DEF
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_pixel_index,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic [7:0]  s_brightness,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic        m_line_level,
    output logic        m_busy_res,
    output logic        m_accepted
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CW = $clog2(MAX_LEDS + 1);
    localparam int EW = (CW > 8) ? CW : 8;

    // configuration registers
    logic [6:0]  led_count_reg;
    logic [15:0] one_high_reg, one_low_reg, zero_high_reg, zero_low_reg, latch_reg;

    // line state
    line_phase_t phase_reg, phase_next;
    logic [AW-1:0] send_pixel_reg, send_pixel_next;
    logic [4:0]    send_bit_reg, send_bit_next;
    logic [15:0]   ticks_reg, ticks_next;

    // pixel store, valid marks and fetched word
    logic [23:0]         mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] valid_reg;
    logic [23:0]         word_reg;
    logic                word_valid_reg;

    // set-pixel pipeline
    logic [7:0]    r_reg, g_reg, b_reg;
    logic [6:0]    br_reg;
    logic [AW-1:0] wr_addr_reg;
    logic          wr_en_reg;
    logic [14:0]   pr_reg, pg_reg, pb_reg;
    logic [27:0]   qr, qg, qb;

    // result registers
    logic level_reg, busy_reg, acc_reg;

    logic [EW-1:0] eff_count, led_ext, max_ext, idx_ext, pix_inc;
    logic [4:0]    bit_sel;
    logic          cur_bit;
    logic [15:0]   tick_sum, dur;
    logic          done;
    logic          level, acc;
    logic [6:0]    br_clamp;

    // effective count, index range, next pixel and brightness clamp
    always_comb begin
        led_ext   = EW'(led_count_reg);
        max_ext   = EW'(MAX_LEDS);
        eff_count = (led_ext > max_ext) ? max_ext : led_ext;
        idx_ext   = EW'(s_pixel_index);
        pix_inc   = EW'(send_pixel_reg) + EW'(1);
        br_clamp  = (s_brightness > BRIGHT_MAX) ? BRIGHT_MAX[6:0] : s_brightness[6:0];
    end

    // bit on the line and phase timer compare
    always_comb begin
        bit_sel  = LAST_BIT - send_bit_reg;
        cur_bit  = word_valid_reg & word_reg[bit_sel];
        tick_sum = ticks_reg + 16'd1;
        unique case (phase_reg)
            PH_HIGH:  dur = cur_bit ? one_high_reg : zero_high_reg;
            PH_LOW:   dur = cur_bit ? one_low_reg : zero_low_reg;
            PH_LATCH: dur = latch_reg;
            default:  dur = latch_reg;
        endcase
        done = (tick_sum >= dur) || (tick_sum == 16'd0);
    end

    // item execution: line advance, refusal, set detection, show start
    always_comb begin
        phase_next      = phase_reg;
        send_pixel_next = send_pixel_reg;
        send_bit_next   = send_bit_reg;
        ticks_next      = ticks_reg;
        level           = 1'b0;
        acc             = 1'b1;
        stat.need_fetch = 1'b0;
        stat.is_set     = 1'b0;
        if (s_operation == OP_TICK) begin
            unique case (phase_reg)
                PH_HIGH: begin
                    level = 1'b1;
                    if (done) begin
                        ticks_next = 16'd0;
                        phase_next = PH_LOW;
                    end else begin
                        ticks_next = tick_sum;
                    end
                end
                PH_LOW: begin
                    if (done) begin
                        ticks_next = 16'd0;
                        if (send_bit_reg >= LAST_BIT) begin
                            send_bit_next = 5'd0;
                            if (pix_inc >= eff_count) begin
                                phase_next = PH_LATCH;
                            end else begin
                                send_pixel_next = pix_inc[AW-1:0];
                                phase_next      = PH_HIGH;
                                stat.need_fetch = 1'b1;
                            end
                        end else begin
                            send_bit_next = send_bit_reg + 5'd1;
                            phase_next    = PH_HIGH;
                        end
                    end else begin
                        ticks_next = tick_sum;
                    end
                end
                PH_LATCH: begin
                    if (done) begin
                        ticks_next      = 16'd0;
                        send_pixel_next = '0;
                        send_bit_next   = 5'd0;
                        phase_next      = PH_IDLE;
                    end else begin
                        ticks_next = tick_sum;
                    end
                end
                default: begin
                end
            endcase
        end else if (phase_reg != PH_IDLE) begin
            acc   = 1'b0;
            level = (phase_reg == PH_HIGH);
        end else if (s_operation == OP_SET) begin
            stat.is_set = 1'b1;
        end else if (s_operation == OP_SHOW) begin
            send_pixel_next = '0;
            send_bit_next   = 5'd0;
            ticks_next      = 16'd0;
            if (eff_count == '0) begin
                phase_next = PH_LATCH;
            end else begin
                phase_next      = PH_HIGH;
                stat.need_fetch = 1'b1;
            end
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg <= RST_LED_COUNT;
            one_high_reg  <= RST_ONE_HIGH;
            one_low_reg   <= RST_ONE_LOW;
            zero_high_reg <= RST_ZERO_HIGH;
            zero_low_reg  <= RST_ZERO_LOW;
            latch_reg     <= RST_LATCH;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LED_COUNT: led_count_reg <= cfg_wdata[6:0];
                CFG_ONE_HIGH:  one_high_reg  <= cfg_wdata;
                CFG_ONE_LOW:   one_low_reg   <= cfg_wdata;
                CFG_ZERO_HIGH: zero_high_reg <= cfg_wdata;
                CFG_ZERO_LOW:  zero_low_reg  <= cfg_wdata;
                CFG_LATCH:     latch_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // line state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            send_pixel_reg <= '0;
            send_bit_reg   <= 5'd0;
            ticks_reg      <= 16'd0;
        end else if (cmd.exec) begin
            phase_reg      <= phase_next;
            send_pixel_reg <= send_pixel_next;
            send_bit_reg   <= send_bit_next;
            ticks_reg      <= ticks_next;
        end
    end

    // valid marks: clear all on clear, set on store write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.exec && s_operation == OP_CLEAR && phase_reg == PH_IDLE) begin
            valid_reg <= '0;
        end else if (cmd.div && wr_en_reg) begin
            valid_reg[wr_addr_reg] <= 1'b1;
        end
    end

    // pixel store write and fetch of the pixel being sent
    always_ff @(posedge aclk) begin
        if (cmd.div && wr_en_reg) begin
            mem[wr_addr_reg] <= {qg[26:19], qr[26:19], qb[26:19]};
        end
        if (cmd.fetch) begin
            word_reg       <= mem[send_pixel_reg];
            word_valid_reg <= valid_reg[send_pixel_reg];
        end
    end

    // set-pixel capture and brightness products
    always_ff @(posedge aclk) begin
        if (cmd.exec && stat.is_set) begin
            r_reg       <= s_red;
            g_reg       <= s_green;
            b_reg       <= s_blue;
            br_reg      <= br_clamp;
            wr_addr_reg <= idx_ext[AW-1:0];
        end
        if (cmd.mul) begin
            pr_reg <= 15'(r_reg * br_reg);
            pg_reg <= 15'(g_reg * br_reg);
            pb_reg <= 15'(b_reg * br_reg);
        end
    end

    // write enable only for an index inside the strip
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_en_reg <= 1'b0;
        end else if (cmd.exec && stat.is_set) begin
            wr_en_reg <= (idx_ext < eff_count);
        end
    end

    // divide by 100 through the reciprocal
    always_comb begin
        qr = 28'(pr_reg * DIV100_MULT);
        qg = 28'(pg_reg * DIV100_MULT);
        qb = 28'(pb_reg * DIV100_MULT);
    end

    // result registers
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            level_reg <= level;
            busy_reg  <= (phase_next != PH_IDLE);
            acc_reg   <= acc;
        end
    end

    assign m_line_level = level_reg;
    assign m_busy_res   = busy_reg;
    assign m_accepted   = acc_reg;

endmodule

[tb/tb_rgb_led_strip_serializer_top.sv]
`timescale 1ns / 100ps

module tb_rgb_led_strip_serializer_top;
    import rlss_pkg::*;

    localparam int LEDS = MAX_LEDS_DEF;
    localparam int IDLE_PCT = 31;
    localparam int HOLD_CYCLES = 200;
    localparam int RANDOM_ITEMS = 120;
    localparam int MAX_PRINTS = 20;

    // register indexes past the end of the map
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] brightness;
    } strip_op_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic accepted;
    } line_status_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_LED_COUNT;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = OP_TICK;
    logic [7:0]  s_pixel_index = '0;
    logic [7:0]  s_red = '0;
    logic [7:0]  s_green = '0;
    logic [7:0]  s_blue = '0;
    logic [7:0]  s_brightness = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_line_level;
    logic        m_busy_res;
    logic        m_accepted;

    rgb_led_strip_serializer_top dut (.*);

    always #1 aclk = ~aclk;

    // shadow registers and line state of the strip driver
    logic [6:0]   strip_count;
    logic [15:0]  one_high;
    logic [15:0]  one_low;
    logic [15:0]  zero_high;
    logic [15:0]  zero_low;
    logic [15:0]  latch_len;
    logic [23:0]  color_mem [LEDS];
    logic         color_ok [LEDS];
    logic [6:0]   tx_pixel;
    logic [4:0]   tx_bit;
    logic [15:0]  tick_cnt;
    line_phase_t  phase;

    line_status_t status_q[$];
    int           err_count = 0;
    int           items_sent = 0;
    bit           steady = 1'b0;
    int           hold_asks = 0;
    logic [1:0]   busy_ops [3] = '{OP_SET, OP_CLEAR, OP_SHOW};

    function automatic void strip_reset();
        strip_count = RST_LED_COUNT;
        one_high = RST_ONE_HIGH;
        one_low = RST_ONE_LOW;
        zero_high = RST_ZERO_HIGH;
        zero_low = RST_ZERO_LOW;
        latch_len = RST_LATCH;
        foreach (color_ok[i]) begin
            color_ok[i] = 1'b0;
            color_mem[i] = '0;
        end
        tx_pixel = '0;
        tx_bit = '0;
        tick_cnt = '0;
        phase = PH_IDLE;
    endfunction

    function automatic void strip_configure(input logic [2:0] idx, input logic [15:0] val);
        case (idx)
            CFG_LED_COUNT: strip_count = val[6:0];
            CFG_ONE_HIGH:  one_high = val;
            CFG_ONE_LOW:   one_low = val;
            CFG_ZERO_HIGH: zero_high = val;
            CFG_ZERO_LOW:  zero_low = val;
            CFG_LATCH:     latch_len = val;
            default: ;
        endcase
    endfunction

    // number of leds a frame really sends
    function automatic int strip_len();
        return (int'(strip_count) > LEDS) ? LEDS : int'(strip_count);
    endfunction

    // bit under transmission, cleared pixels read as zero
    function automatic logic tx_data_bit();
        logic [23:0] word;
        word = '0;
        if (int'(tx_pixel) < LEDS && color_ok[tx_pixel])
            word = color_mem[tx_pixel];
        return word[LAST_BIT - tx_bit];
    endfunction

    // count one tick of the current phase, a zero duration ends after one tick
    function automatic bit phase_expired(input logic [15:0] dur);
        tick_cnt = tick_cnt + 16'd1;
        return (tick_cnt >= dur) || (tick_cnt == 16'd0);
    endfunction

    // one clock of the line waveform, returns the level during it
    function automatic logic line_tick();
        logic lvl;
        logic b;
        lvl = 1'b0;
        case (phase)
            PH_HIGH: begin
                lvl = 1'b1;
                b = tx_data_bit();
                if (phase_expired(b ? one_high : zero_high)) begin
                    tick_cnt = '0;
                    phase = PH_LOW;
                end
            end
            PH_LOW: begin
                b = tx_data_bit();
                if (phase_expired(b ? one_low : zero_low)) begin
                    tick_cnt = '0;
                    if (tx_bit >= LAST_BIT) begin
                        tx_bit = '0;
                        if (int'(tx_pixel) + 1 >= strip_len()) begin
                            phase = PH_LATCH;
                        end else begin
                            tx_pixel = tx_pixel + 7'd1;
                            phase = PH_HIGH;
                        end
                    end else begin
                        tx_bit = tx_bit + 5'd1;
                        phase = PH_HIGH;
                    end
                end
            end
            PH_LATCH: begin
                if (phase_expired(latch_len)) begin
                    tick_cnt = '0;
                    tx_pixel = '0;
                    tx_bit = '0;
                    phase = PH_IDLE;
                end
            end
            default: ;
        endcase
        return lvl;
    endfunction

    // apply one operation to the shadow state and return its status
    function automatic line_status_t strip_apply(input strip_op_t op);
        line_status_t res;
        int br;
        res = '0;
        res.accepted = 1'b1;
        if (op.operation == OP_TICK) begin
            res.line_level = line_tick();
        end else if (phase != PH_IDLE) begin
            res.accepted = 1'b0;
            res.line_level = (phase == PH_HIGH);
        end else if (op.operation == OP_SET) begin
            br = (op.brightness > BRIGHT_MAX) ? int'(BRIGHT_MAX) : int'(op.brightness);
            if (int'(op.pixel_index) < strip_len()) begin
                color_mem[op.pixel_index] = {8'((int'(op.green) * br) / int'(BRIGHT_MAX)),
                                             8'((int'(op.red) * br) / int'(BRIGHT_MAX)),
                                             8'((int'(op.blue) * br) / int'(BRIGHT_MAX))};
                color_ok[op.pixel_index] = 1'b1;
            end
        end else if (op.operation == OP_CLEAR) begin
            foreach (color_ok[i]) color_ok[i] = 1'b0;
        end else begin
            tx_pixel = '0;
            tx_bit = '0;
            tick_cnt = '0;
            phase = (strip_len() == 0) ? PH_LATCH : PH_HIGH;
        end
        res.busy_res = (phase != PH_IDLE);
        return res;
    endfunction

    function automatic strip_op_t make_op(input logic [1:0] code, input logic [7:0] idx,
                                          input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [7:0] br);
        strip_op_t op;
        op.operation = code;
        op.pixel_index = idx;
        op.red = r;
        op.green = g;
        op.blue = b;
        op.brightness = br;
        return op;
    endfunction

    function automatic strip_op_t random_op(input logic [1:0] code);
        return make_op(code, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom));
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // offer one transaction, predict its status once it is taken
    task automatic send_op(input strip_op_t op);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
            gap = $urandom_range(1, 2);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op.operation;
        s_pixel_index <= op.pixel_index;
        s_red <= op.red;
        s_green <= op.green;
        s_blue <= op.blue;
        s_brightness <= op.brightness;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        status_q.push_back(strip_apply(op));
        items_sent++;
    endtask

    task automatic idle_bus();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (status_q.size() != 0) @(posedge aclk);
    endtask

    // register write with nothing in flight
    task automatic program_reg(input logic [2:0] idx, input logic [15:0] val);
        idle_bus();
        wait_drained();
        repeat (3) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        strip_configure(idx, val);
    endtask

    // tick until the frame and latch are over, with refused operations mixed in
    task automatic run_out_frame(input int noise_pct);
        while (phase != PH_IDLE) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_op(random_op(busy_ops[$urandom_range(0, 2)]));
            else
                send_op(random_op(OP_TICK));
        end
    endtask

    // result receiver: random stalls, steady stretches and long holds
    always @(posedge aclk) begin : result_ready
        int hold_left;
        int hold_served;
        if (hold_left == 0 && hold_served != hold_asks) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : result_check
        line_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (status_q.size() == 0) begin
                report_mismatch("result transaction with nothing pending");
            end else begin
                want = status_q.pop_front();
                if (m_line_level !== want.line_level)
                    report_mismatch($sformatf("line_level %b, predicted %b",
                                              m_line_level, want.line_level));
                if (m_busy_res !== want.busy_res)
                    report_mismatch($sformatf("busy_res %b, predicted %b",
                                              m_busy_res, want.busy_res));
                if (m_accepted !== want.accepted)
                    report_mismatch($sformatf("accepted %b, predicted %b",
                                              m_accepted, want.accepted));
            end
        end
    end

    // default registers: dimming corners, dropped indexes, refused operations
    task automatic test_default_frame();
        send_op(random_op(OP_TICK));
        // green msb clear so the frame opens with a zero bit then a one bit
        send_op(make_op(OP_SET, 8'd0, 8'hFF, 8'h7F, 8'hFF, 8'd100));
        send_op(make_op(OP_SET, 8'd1, 8'hFF, 8'h00, 8'h80, 8'd255));
        send_op(make_op(OP_SET, 8'd2, 8'd200, 8'd100, 8'd50, 8'd0));
        send_op(make_op(OP_SET, 8'd3, 8'hFF, 8'hFF, 8'hFF, 8'd101));
        send_op(make_op(OP_SET, 8'd4, 8'd1, 8'd2, 8'd3, 8'd50));
        send_op(make_op(OP_SET, 8'd5, 8'hAA, 8'h55, 8'h0F, 8'd99));
        send_op(make_op(OP_SET, 8'd6, 8'h81, 8'h7E, 8'hC3, 8'd100));
        send_op(make_op(OP_SET, 8'd7, 8'h3C, 8'hE7, 8'h18, 8'd1));
        send_op(make_op(OP_SET, 8'd8, 8'hFF, 8'hFF, 8'hFF, 8'd100));
        send_op(make_op(OP_SET, 8'd255, 8'h00, 8'h00, 8'h00, 8'd100));
        steady = 1'b1;
        send_op(random_op(OP_SHOW));
        repeat (30) send_op(random_op(OP_TICK));
        send_op(random_op(OP_SET));
        send_op(random_op(OP_CLEAR));
        send_op(random_op(OP_SHOW));
        repeat (95) send_op(random_op(OP_TICK));
        steady = 1'b0;
        // both bit kinds timed at defaults, finish the frame with short timings
        program_reg(CFG_LED_COUNT, 16'd1);
        program_reg(CFG_ONE_HIGH, 16'd1);
        program_reg(CFG_ONE_LOW, 16'd1);
        program_reg(CFG_ZERO_HIGH, 16'd1);
        program_reg(CFG_ZERO_LOW, 16'd1);
        program_reg(CFG_LATCH, 16'd3);
        run_out_frame(0);
    endtask

    // short timings, then write every remaining pixel
    task automatic test_fill_store();
        strip_op_t op;
        program_reg(CFG_ONE_HIGH, 16'd1);
        program_reg(CFG_ONE_LOW, 16'd0);
        program_reg(CFG_ZERO_HIGH, 16'd2);
        program_reg(CFG_ZERO_LOW, 16'd1);
        program_reg(CFG_LATCH, 16'd3);
        program_reg(CFG_LED_COUNT, 16'hFF40);
        for (int i = 8; i < LEDS; i++) begin
            op = random_op(OP_SET);
            op.pixel_index = 8'(i);
            send_op(op);
        end
    endtask

    // count above capacity still drops indexes past the store
    task automatic test_full_strip();
        program_reg(CFG_LED_COUNT, 16'h007F);
        send_op(make_op(OP_SET, 8'd64, 8'hFF, 8'hFF, 8'hFF, 8'd100));
        send_op(make_op(OP_SET, 8'd63, 8'hC0, 8'h03, 8'h5A, 8'd100));
        steady = 1'b1;
        send_op(random_op(OP_SHOW));
        program_reg(CFG_LED_COUNT, 16'd1);
        run_out_frame(1);
        steady = 1'b0;
    endtask

    // cleared pixels go out as zero
    task automatic test_clear_all();
        program_reg(CFG_LED_COUNT, 16'd1);
        send_op(random_op(OP_CLEAR));
        send_op(random_op(OP_SHOW));
        run_out_frame(3);
        send_op(make_op(OP_SET, 8'd0, 8'hF0, 8'h0F, 8'h99, 8'd100));
        send_op(random_op(OP_SHOW));
        run_out_frame(3);
    endtask

    // no leds: show goes straight to latch, long latch cut short, then zero latch
    task automatic test_zero_count_latch();
        program_reg(CFG_LED_COUNT, 16'hFF80);
        program_reg(CFG_LATCH, 16'hFFFF);
        send_op(make_op(OP_SET, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'd100));
        steady = 1'b1;
        send_op(random_op(OP_SHOW));
        repeat (20) send_op(random_op(OP_TICK));
        steady = 1'b0;
        program_reg(CFG_LATCH, 16'd25);
        run_out_frame(0);
        program_reg(CFG_LATCH, 16'h0000);
        send_op(random_op(OP_SHOW));
        run_out_frame(0);
    endtask

    // writes past the register map change nothing
    task automatic test_spare_registers();
        program_reg(CFG_LED_COUNT, 16'd1);
        program_reg(CFG_SPARE_A, 16'hFFFF);
        program_reg(CFG_SPARE_B, 16'h0000);
        send_op(random_op(OP_SHOW));
        run_out_frame(0);
    endtask

    // timings and count rewritten while a frame is on the line
    task automatic test_midframe_change();
        program_reg(CFG_LED_COUNT, 16'd3);
        program_reg(CFG_ONE_HIGH, 16'hFFFF);
        program_reg(CFG_ONE_LOW, 16'hFFFF);
        program_reg(CFG_ZERO_HIGH, 16'hFFFF);
        program_reg(CFG_ZERO_LOW, 16'hFFFF);
        program_reg(CFG_LATCH, 16'hFFFF);
        send_op(random_op(OP_SHOW));
        repeat (20) send_op(random_op(OP_TICK));
        program_reg(CFG_ONE_HIGH, 16'd1);
        program_reg(CFG_ZERO_HIGH, 16'd1);
        repeat (5) send_op(random_op(OP_TICK));
        program_reg(CFG_ONE_LOW, 16'd1);
        program_reg(CFG_ZERO_LOW, 16'd2);
        repeat (25) send_op(random_op(OP_TICK));
        program_reg(CFG_LED_COUNT, 16'd1);
        program_reg(CFG_LATCH, 16'd4);
        run_out_frame(2);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        send_op(random_op(OP_SHOW));
        hold_asks++;
        repeat (40) send_op(random_op(OP_TICK));
        run_out_frame(2);
    endtask

    // random settings, pixel updates, frames and noise
    task automatic test_random_frames();
        int start;
        int n;
        int cnt;
        strip_op_t op;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       cnt = 0;
                1:       cnt = $urandom_range(3, 6);
                default: cnt = $urandom_range(1, 2);
            endcase
            program_reg(CFG_LED_COUNT, (16'($urandom) & 16'hFF80) | 16'(cnt));
            program_reg(CFG_ONE_HIGH, 16'($urandom_range(0, 2)));
            program_reg(CFG_ONE_LOW, 16'($urandom_range(0, 2)));
            program_reg(CFG_ZERO_HIGH, 16'($urandom_range(0, 2)));
            program_reg(CFG_ZERO_LOW, 16'($urandom_range(0, 2)));
            program_reg(CFG_LATCH, 16'($urandom_range(0, 8)));
            if ($urandom_range(0, 6) == 0) begin
                // unstructured operations
                n = $urandom_range(5, 20);
                repeat (n) send_op(random_op(2'($urandom_range(0, 3))));
            end else begin
                n = $urandom_range(0, 6);
                repeat (n) begin
                    op = random_op(OP_SET);
                    if ($urandom_range(0, 3) != 0)
                        op.pixel_index = 8'($urandom_range(0, strip_len() + 1));
                    case ($urandom_range(0, 3))
                        0:       op.brightness = BRIGHT_MAX;
                        1:       op.brightness = 8'($urandom_range(101, 255));
                        default: op.brightness = 8'($urandom_range(0, 100));
                    endcase
                    send_op(op);
                end
                if ($urandom_range(0, 9) == 0)
                    send_op(random_op(OP_CLEAR));
                repeat ($urandom_range(0, 3)) send_op(random_op(OP_TICK));
                send_op(random_op(OP_SHOW));
            end
            run_out_frame(5);
        end
    endtask

    initial begin
        strip_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_frame();
        test_fill_store();
        test_full_strip();
        test_clear_all();
        test_zero_count_latch();
        test_spare_registers();
        test_midframe_change();
        test_backpressure();
        test_random_frames();
        idle_bus();
        wait_drained();
        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/rlss_pkg.sv
rtl/core/rlss_ctrl.sv
rtl/core/rlss_datapath.sv
rtl/core/rgb_led_strip_serializer_top.sv
tb/tb_rgb_led_strip_serializer_top.sv
